// ===== rtl/wzh_pkg.sv =====
// Shared types and constants for the window z-order hit-test block.
package wzh_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int SLOT_W    = 3;
    localparam int COORD_W   = 12;
    localparam int OWNER_W   = 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_RAISE   = 2'd2,
        CMD_HIT     = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RAISE,
        S_HIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_PULL
    } t_cell_op;

    // Window rectangle as held in a cell; right/bottom are inclusive edges, no wrap.
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W:0]   right;
        logic [COORD_W:0]   bottom;
        logic [OWNER_W-1:0] owner;
    } t_rect;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cell_op           op;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_cell_ctrl;

endpackage

// ===== rtl/wzh_cell.sv =====
// One stacking-order cell: holds one entry, shifts to and from its neighbours.
module wzh_cell #(
    parameter int SLOT_IW = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wzh_pkg::t_cell_ctrl   i_ctrl,
    input  logic [SLOT_IW-1:0]    i_pull_slot,
    // entry from the cell above (or the new entry at the top)
    input  logic                  i_up_valid,
    input  logic [SLOT_IW-1:0]    i_up_slot,
    input  wzh_pkg::t_rect        i_up_rect,
    // entry from the cell below
    input  logic                  i_dn_valid,
    input  logic [SLOT_IW-1:0]    i_dn_slot,
    input  wzh_pkg::t_rect        i_dn_rect,
    // ripple chains, top to bottom
    input  logic                  i_pulled,
    output logic                  o_pulled,
    input  logic                  i_hit_above,
    output logic                  o_hit_above,
    // own entry
    output logic                  o_valid,
    output logic [SLOT_IW-1:0]    o_slot,
    output wzh_pkg::t_rect        o_rect,
    // topmost hit and removed entry, zero when not this cell
    output logic                  o_sel,
    output logic [SLOT_IW-1:0]    o_sel_slot,
    output logic [wzh_pkg::OWNER_W-1:0] o_sel_owner,
    output wzh_pkg::t_rect        o_cap_rect
);

    logic               r_valid, n_valid;
    logic [SLOT_IW-1:0] r_slot, n_slot;
    wzh_pkg::t_rect     r_rect, n_rect;
    logic               r_hit, n_hit;
    logic               match;

    assign match       = r_valid && (r_slot == i_pull_slot);
    assign o_pulled    = i_pulled | match;
    assign o_hit_above = i_hit_above | r_hit;
    assign o_sel       = r_hit && !i_hit_above;
    assign o_sel_slot  = o_sel ? r_slot : '0;
    assign o_sel_owner = o_sel ? r_rect.owner : '0;
    assign o_cap_rect  = match ? r_rect : '0;
    assign o_valid     = r_valid;
    assign o_slot      = r_slot;
    assign o_rect      = r_rect;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        n_rect  = r_rect;
        case (i_ctrl.op)
            wzh_pkg::OP_PUSH: begin
                n_valid = i_up_valid;
                n_slot  = i_up_slot;
                n_rect  = i_up_rect;
            end
            wzh_pkg::OP_PULL: begin
                if (o_pulled) begin
                    n_valid = i_dn_valid;
                    n_slot  = i_dn_slot;
                    n_rect  = i_dn_rect;
                end
            end
            default: begin
            end
        endcase
        n_hit = r_valid
             && (i_ctrl.px >= r_rect.left) && ({1'b0, i_ctrl.px} <= r_rect.right)
             && (i_ctrl.py >= r_rect.top)  && ({1'b0, i_ctrl.py} <= r_rect.bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
        r_slot <= n_slot;
        r_rect <= n_rect;
    end

endmodule

// ===== rtl/window_zorder_hit_test.sv =====
// Top level of the window z-order table: sequencer plus a chain of stacking cells.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | in        | i_in_valid / o_in_stall    | cmd, slot, pos_x/y, width, height,
//          |           |                            | owner
//  out     | out       | o_out_valid / i_out_stall  | status, result_slot, result_owner,
//          |           |                            | focus_valid, focus_slot
//
// A transfer in moves the sequencer to EXEC, which shifts the cell chain; raise then
// goes through RAISE for its second shift and hit test through HIT for the registered
// compares, while create, destroy and failed ops go from EXEC straight to DONE. In DONE
// the result is loaded into the output register and the sequencer returns to IDLE; only
// then is the next item taken, so a new item is not accepted while one is in flight.
// Synchronous active-low reset empties the chain and clears the focus; no sweep.
// A stalled output holds the sequencer in its final state; the output register
// frees the input side as soon as the waiting result is taken.
module window_zorder_hit_test #(
    parameter int SLOTS = wzh_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wzh_pkg::CMD_W-1:0]     i_cmd,
    input  logic [wzh_pkg::SLOT_W-1:0]    i_slot,
    input  logic [wzh_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [wzh_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [wzh_pkg::COORD_W-1:0]   i_width,
    input  logic [wzh_pkg::COORD_W-1:0]   i_height,
    input  logic [wzh_pkg::OWNER_W-1:0]   i_owner,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wzh_pkg::STATUS_W-1:0]  o_status,
    output logic [wzh_pkg::SLOT_W-1:0]    o_result_slot,
    output logic [wzh_pkg::OWNER_W-1:0]   o_result_owner,
    output logic                          o_focus_valid,
    output logic [wzh_pkg::SLOT_W-1:0]    o_focus_slot
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // latched command
    wzh_pkg::t_state                  r_state, n_state;
    wzh_pkg::t_cmd                    r_cmd;
    logic [wzh_pkg::SLOT_W-1:0]       r_slot;
    logic [wzh_pkg::COORD_W-1:0]      r_px, r_py, r_w, r_h;
    logic [wzh_pkg::OWNER_W-1:0]      r_own;

    // slot bookkeeping and focus
    logic [SLOTS-1:0]                 r_used, n_used;
    logic                             r_focus_on, n_focus_on;
    logic [IW-1:0]                    r_focus_idx, n_focus_idx;
    wzh_pkg::t_rect                   r_cap, n_cap;

    // pending result
    wzh_pkg::t_status                 r_res_status, n_res_status;
    logic [IW-1:0]                    r_res_slot, n_res_slot;
    logic [wzh_pkg::OWNER_W-1:0]      r_res_owner, n_res_owner;

    // output register
    logic                             r_ovalid, n_ovalid;
    wzh_pkg::t_status                 r_o_status;
    logic [wzh_pkg::SLOT_W-1:0]       r_o_slot, r_o_fslot;
    logic [wzh_pkg::OWNER_W-1:0]      r_o_owner;
    logic                             r_o_fvalid;
    logic                             out_load;

    // cell chain
    wzh_pkg::t_cell_ctrl              cell_ctrl;
    logic [IW-1:0]                    new_slot;
    wzh_pkg::t_rect                   new_rect;
    logic [SLOTS-1:0]                 c_valid, c_sel;
    logic [IW-1:0]                    c_slot     [SLOTS];
    wzh_pkg::t_rect                   c_rect     [SLOTS];
    logic [IW-1:0]                    c_sel_slot [SLOTS];
    logic [wzh_pkg::OWNER_W-1:0]      c_sel_own  [SLOTS];
    wzh_pkg::t_rect                   c_cap      [SLOTS];
    logic [SLOTS:0]                   pull_chain, hit_chain;

    // decoded helpers
    logic                             in_take;
    logic                             slot_ok;
    logic [IW-1:0]                    slot_idx;
    logic                             any_free;
    logic [IW-1:0]                    free_idx;
    logic                             any_hit;
    logic [IW-1:0]                    hit_slot;
    logic [wzh_pkg::OWNER_W-1:0]      hit_own;
    wzh_pkg::t_rect                   cap_rect;

    assign o_in_stall = (r_state != wzh_pkg::S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign slot_ok    = (32'(r_slot) < SLOTS) && r_used[IW'(r_slot)];
    assign slot_idx   = IW'(r_slot);
    assign out_load   = (r_state == wzh_pkg::S_DONE) && (!r_ovalid || !i_out_stall);

    assign pull_chain[0] = 1'b0;
    assign hit_chain[0]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            logic               up_valid, dn_valid;
            logic [IW-1:0]      up_slot, dn_slot;
            wzh_pkg::t_rect     up_rect, dn_rect;

            if (gi == 0) begin : g_top
                assign up_valid = 1'b1;
                assign up_slot  = new_slot;
                assign up_rect  = new_rect;
            end else begin : g_mid
                assign up_valid = c_valid[gi-1];
                assign up_slot  = c_slot[gi-1];
                assign up_rect  = c_rect[gi-1];
            end

            if (gi == SLOTS - 1) begin : g_bot
                assign dn_valid = 1'b0;
                assign dn_slot  = '0;
                assign dn_rect  = '0;
            end else begin : g_inner
                assign dn_valid = c_valid[gi+1];
                assign dn_slot  = c_slot[gi+1];
                assign dn_rect  = c_rect[gi+1];
            end

            wzh_cell #(
                .SLOT_IW (IW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (cell_ctrl),
                .i_pull_slot (slot_idx),
                .i_up_valid  (up_valid),
                .i_up_slot   (up_slot),
                .i_up_rect   (up_rect),
                .i_dn_valid  (dn_valid),
                .i_dn_slot   (dn_slot),
                .i_dn_rect   (dn_rect),
                .i_pulled    (pull_chain[gi]),
                .o_pulled    (pull_chain[gi+1]),
                .i_hit_above (hit_chain[gi]),
                .o_hit_above (hit_chain[gi+1]),
                .o_valid     (c_valid[gi]),
                .o_slot      (c_slot[gi]),
                .o_rect      (c_rect[gi]),
                .o_sel       (c_sel[gi]),
                .o_sel_slot  (c_sel_slot[gi]),
                .o_sel_owner (c_sel_own[gi]),
                .o_cap_rect  (c_cap[gi])
            );
        end
    endgenerate

    // Topmost hit and the entry taken out for raise; at most one cell contributes.
    always_comb begin
        any_hit  = |c_sel;
        hit_slot = '0;
        hit_own  = '0;
        cap_rect = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_slot = hit_slot | c_sel_slot[i];
            hit_own  = hit_own  | c_sel_own[i];
            cap_rect = cap_rect | c_cap[i];
        end
    end

    // Lowest free slot.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // Sequencer: next state, cell commands, bookkeeping.
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_focus_on   = r_focus_on;
        n_focus_idx  = r_focus_idx;
        n_cap        = r_cap;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_owner  = r_res_owner;

        cell_ctrl.op = wzh_pkg::OP_HOLD;
        cell_ctrl.px = r_px;
        cell_ctrl.py = r_py;

        if (r_state == wzh_pkg::S_RAISE) begin
            new_slot = slot_idx;
            new_rect = r_cap;
        end else begin
            new_slot        = free_idx;
            new_rect.left   = r_px;
            new_rect.top    = r_py;
            new_rect.right  = {1'b0, r_px} + {1'b0, r_w};
            new_rect.bottom = {1'b0, r_py} + {1'b0, r_h};
            new_rect.owner  = r_own;
        end

        case (r_state)
            wzh_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = wzh_pkg::S_EXEC;
                end
            end
            wzh_pkg::S_EXEC: begin
                n_res_status = wzh_pkg::ST_OK;
                n_res_slot   = '0;
                n_res_owner  = '0;
                n_state      = wzh_pkg::S_DONE;
                case (r_cmd)
                    wzh_pkg::CMD_CREATE: begin
                        if (!any_free) begin
                            n_res_status = wzh_pkg::ST_FULL;
                        end else begin
                            cell_ctrl.op     = wzh_pkg::OP_PUSH;
                            n_used[free_idx] = 1'b1;
                            n_res_slot       = free_idx;
                            n_res_owner      = r_own;
                        end
                    end
                    wzh_pkg::CMD_DESTROY: begin
                        if (!slot_ok) begin
                            n_res_status = wzh_pkg::ST_EMPTY;
                        end else begin
                            cell_ctrl.op     = wzh_pkg::OP_PULL;
                            n_used[slot_idx] = 1'b0;
                            if (r_focus_on && (r_focus_idx == slot_idx)) begin
                                n_focus_on  = 1'b0;
                                n_focus_idx = '0;
                            end
                        end
                    end
                    wzh_pkg::CMD_RAISE: begin
                        if (!slot_ok) begin
                            n_res_status = wzh_pkg::ST_EMPTY;
                        end else begin
                            cell_ctrl.op = wzh_pkg::OP_PULL;
                            n_cap        = cap_rect;
                            n_state      = wzh_pkg::S_RAISE;
                        end
                    end
                    default: begin
                        // hit test: compares are registered in the cells this cycle
                        n_state = wzh_pkg::S_HIT;
                    end
                endcase
            end
            wzh_pkg::S_RAISE: begin
                cell_ctrl.op = wzh_pkg::OP_PUSH;
                n_state      = wzh_pkg::S_DONE;
            end
            wzh_pkg::S_HIT: begin
                if (any_hit) begin
                    n_res_slot  = hit_slot;
                    n_res_owner = hit_own;
                    n_focus_on  = 1'b1;
                    n_focus_idx = hit_slot;
                end else begin
                    n_res_status = wzh_pkg::ST_MISS;
                    n_focus_on   = 1'b0;
                    n_focus_idx  = '0;
                end
                n_state = wzh_pkg::S_DONE;
            end
            wzh_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = wzh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wzh_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wzh_pkg::S_IDLE;
            r_used      <= '0;
            r_focus_on  <= 1'b0;
            r_focus_idx <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_focus_on  <= n_focus_on;
            r_focus_idx <= n_focus_idx;
            r_ovalid    <= n_ovalid;
        end

        if (in_take) begin
            r_cmd  <= wzh_pkg::t_cmd'(i_cmd);
            r_slot <= i_slot;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_w    <= i_width;
            r_h    <= i_height;
            r_own  <= i_owner;
        end

        r_cap        <= n_cap;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_owner  <= n_res_owner;

        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= wzh_pkg::SLOT_W'(r_res_slot);
            r_o_owner  <= r_res_owner;
            r_o_fvalid <= r_focus_on;
            r_o_fslot  <= r_focus_on ? wzh_pkg::SLOT_W'(r_focus_idx) : '0;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_o_status;
    assign o_result_slot  = r_o_slot;
    assign o_result_owner = r_o_owner;
    assign o_focus_valid  = r_o_fvalid;
    assign o_focus_slot   = r_o_fslot;

endmodule

// ===== dv/wzh_stack_checker.sv =====
// Checker for the window z-order block: tracks the stacking table and checks every result.
module wzh_stack_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [wzh_pkg::CMD_W-1:0]      i_cmd,
    input  logic [wzh_pkg::SLOT_W-1:0]     i_slot,
    input  logic [wzh_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [wzh_pkg::COORD_W-1:0]    i_pos_y,
    input  logic [wzh_pkg::COORD_W-1:0]    i_width,
    input  logic [wzh_pkg::COORD_W-1:0]    i_height,
    input  logic [wzh_pkg::OWNER_W-1:0]    i_owner,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [wzh_pkg::STATUS_W-1:0]   i_status,
    input  logic [wzh_pkg::SLOT_W-1:0]     i_result_slot,
    input  logic [wzh_pkg::OWNER_W-1:0]    i_result_owner,
    input  logic                           i_focus_valid,
    input  logic [wzh_pkg::SLOT_W-1:0]     i_focus_slot,
    output int                             o_fail_count,
    output int                             o_owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        wzh_pkg::t_status            status;
        logic [wzh_pkg::SLOT_W-1:0]  hit_slot;
        logic [wzh_pkg::OWNER_W-1:0] hit_owner;
        logic                        focus_valid;
        logic [wzh_pkg::SLOT_W-1:0]  focus_slot;
    } t_wz_result;

    // Shadow copy of the window table
    logic [wzh_pkg::SLOTS_DEF-1:0] used;
    logic [wzh_pkg::COORD_W-1:0]   win_left   [wzh_pkg::SLOTS_DEF];
    logic [wzh_pkg::COORD_W-1:0]   win_top    [wzh_pkg::SLOTS_DEF];
    logic [wzh_pkg::COORD_W-1:0]   win_width  [wzh_pkg::SLOTS_DEF];
    logic [wzh_pkg::COORD_W-1:0]   win_height [wzh_pkg::SLOTS_DEF];
    logic [wzh_pkg::OWNER_W-1:0]   win_owner  [wzh_pkg::SLOTS_DEF];
    logic [wzh_pkg::SLOT_W-1:0]    z_list     [wzh_pkg::SLOTS_DEF];   // entry 0 is the top
    int                            z_count;
    logic                          focus_on;
    logic [wzh_pkg::SLOT_W-1:0]    focus_at;

    t_wz_result owed_q[$];

    initial begin
        o_fail_count = 0;
        o_owed_count = 0;
    end

    function automatic void z_remove(input logic [wzh_pkg::SLOT_W-1:0] s);
        int j;
        j = 0;
        for (int i = 0; i < z_count; i++) begin
            if (z_list[i] != s) begin
                z_list[j] = z_list[i];
                j++;
            end
        end
        z_count = j;
    endfunction

    function automatic void z_push_top(input logic [wzh_pkg::SLOT_W-1:0] s);
        if (z_count < wzh_pkg::SLOTS_DEF) begin
            for (int i = z_count; i > 0; i--)
                z_list[i] = z_list[i-1];
            z_list[0] = s;
            z_count++;
        end
    endfunction

    function automatic t_wz_result apply_command(
        input wzh_pkg::t_cmd               c,
        input logic [wzh_pkg::SLOT_W-1:0]  s,
        input logic [wzh_pkg::COORD_W-1:0] px,
        input logic [wzh_pkg::COORD_W-1:0] py,
        input logic [wzh_pkg::COORD_W-1:0] w,
        input logic [wzh_pkg::COORD_W-1:0] h,
        input logic [wzh_pkg::OWNER_W-1:0] own
    );
        t_wz_result                 r;
        int                         free_at;
        logic                       hit;
        logic [wzh_pkg::SLOT_W-1:0] k;
        r = '0;
        case (c)
            wzh_pkg::CMD_CREATE: begin
                free_at = -1;
                for (int i = wzh_pkg::SLOTS_DEF - 1; i >= 0; i--)
                    if (!used[i]) free_at = i;
                if (free_at < 0) begin
                    r.status = wzh_pkg::ST_FULL;
                end else begin
                    used[free_at]       = 1'b1;
                    win_left[free_at]   = px;
                    win_top[free_at]    = py;
                    win_width[free_at]  = w;
                    win_height[free_at] = h;
                    win_owner[free_at]  = own;
                    z_push_top(wzh_pkg::SLOT_W'(free_at));
                    r.hit_slot  = wzh_pkg::SLOT_W'(free_at);
                    r.hit_owner = own;
                end
            end
            wzh_pkg::CMD_DESTROY: begin
                if (!used[s]) begin
                    r.status = wzh_pkg::ST_EMPTY;
                end else begin
                    z_remove(s);
                    used[s] = 1'b0;
                    if (focus_on && focus_at == s) begin
                        focus_on = 1'b0;
                        focus_at = '0;
                    end
                end
            end
            wzh_pkg::CMD_RAISE: begin
                if (!used[s]) begin
                    r.status = wzh_pkg::ST_EMPTY;
                end else begin
                    z_remove(s);
                    z_push_top(s);
                end
            end
            default: begin
                // hit test: topmost window wins; right and bottom edges inclusive, no wrap
                hit = 1'b0;
                for (int i = 0; i < z_count; i++) begin
                    k = z_list[i];
                    if (!hit && win_left[k] <= px && win_top[k] <= py &&
                        13'(px) <= 13'(win_left[k]) + 13'(win_width[k]) &&
                        13'(py) <= 13'(win_top[k]) + 13'(win_height[k])) begin
                        hit         = 1'b1;
                        r.hit_slot  = k;
                        r.hit_owner = win_owner[k];
                    end
                end
                if (hit) begin
                    focus_on = 1'b1;
                    focus_at = r.hit_slot;
                end else begin
                    r.status = wzh_pkg::ST_MISS;
                    focus_on = 1'b0;
                    focus_at = '0;
                end
            end
        endcase
        r.focus_valid = focus_on;
        r.focus_slot  = focus_on ? focus_at : '0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_wz_result want;
        if (!i_rst_n) begin
            used     = '0;
            z_count  = 0;
            focus_on = 1'b0;
            focus_at = '0;
            owed_q.delete();
        end else begin
            // result side first, so a same-edge input transfer queues behind it
            if (i_out_valid && !i_out_stall) begin
                if (owed_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("status", 8'(want.status), 8'(i_status));
                    check_field("result_slot", 8'(want.hit_slot), 8'(i_result_slot));
                    check_field("result_owner", want.hit_owner, i_result_owner);
                    check_field("focus_valid", 8'(want.focus_valid), 8'(i_focus_valid));
                    check_field("focus_slot", 8'(want.focus_slot), 8'(i_focus_slot));
                end
            end
            if (i_in_valid && !i_in_stall)
                owed_q.push_back(apply_command(wzh_pkg::t_cmd'(i_cmd), i_slot, i_pos_x,
                                               i_pos_y, i_width, i_height, i_owner));
        end
        o_owed_count = owed_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: window commands into the z-order block, checker alongside, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_ITEMS   = 60;    // tail of the run with no idling on either side
    localparam int LONG_HOLD    = 60;    // receiver hold-off, cycles
    localparam int HOLD_AT      = 150;   // input transfers before the long hold-off
    localparam int SETTLE       = 20;    // cycles after the last result

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [wzh_pkg::CMD_W-1:0]      i_cmd = '0;
    logic [wzh_pkg::SLOT_W-1:0]     i_slot = '0;
    logic [wzh_pkg::COORD_W-1:0]    i_pos_x = '0;
    logic [wzh_pkg::COORD_W-1:0]    i_pos_y = '0;
    logic [wzh_pkg::COORD_W-1:0]    i_width = '0;
    logic [wzh_pkg::COORD_W-1:0]    i_height = '0;
    logic [wzh_pkg::OWNER_W-1:0]    i_owner = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [wzh_pkg::STATUS_W-1:0]   o_status;
    logic [wzh_pkg::SLOT_W-1:0]     o_result_slot;
    logic [wzh_pkg::OWNER_W-1:0]    o_result_owner;
    logic                           o_focus_valid;
    logic [wzh_pkg::SLOT_W-1:0]     o_focus_slot;

    int  fail_count;
    int  owed_count;
    int  n_sent = 0;
    bit  calm = 1'b0;

    // Receiver idling state
    int  stall_left = 0;
    bit  hold_done = 1'b0;

    // Last rectangle created, used to aim hit tests at its edges
    logic [wzh_pkg::COORD_W-1:0] last_x = '0;
    logic [wzh_pkg::COORD_W-1:0] last_y = '0;
    logic [wzh_pkg::COORD_W-1:0] last_w = '0;
    logic [wzh_pkg::COORD_W-1:0] last_h = '0;

    always #1 i_clk = ~i_clk;

    window_zorder_hit_test u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_owner        (i_owner),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_result_owner (o_result_owner),
        .o_focus_valid  (o_focus_valid),
        .o_focus_slot   (o_focus_slot)
    );

    wzh_stack_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_owner        (i_owner),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_result_slot  (o_result_slot),
        .i_result_owner (o_result_owner),
        .i_focus_valid  (o_focus_valid),
        .i_focus_slot   (o_focus_slot),
        .o_fail_count   (fail_count),
        .o_owed_count   (owed_count)
    );

    // Offer one command and hold it until the transfer happens. An optional idle
    // burst goes first; valid is only ever assigned once per falling edge.
    task automatic send_item(input wzh_pkg::t_cmd c, input logic [wzh_pkg::SLOT_W-1:0] s,
                             input logic [wzh_pkg::COORD_W-1:0] x,
                             input logic [wzh_pkg::COORD_W-1:0] y,
                             input logic [wzh_pkg::COORD_W-1:0] w,
                             input logic [wzh_pkg::COORD_W-1:0] h,
                             input logic [wzh_pkg::OWNER_W-1:0] own);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_slot     <= s;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_width    <= w;
        i_height   <= h;
        i_owner    <= own;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    // Result side: random stall bursts, plus one long hold-off once enough transfers
    // have gone in, so the block backs up and stalls its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && !hold_done && n_sent >= HOLD_AT) begin
            hold_done   <= 1'b1;
            stall_left  <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, point windows, extremes, edges, raise/destroy of
        // the focused window and a full table.
        send_item(wzh_pkg::CMD_HIT,     3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // miss
        send_item(wzh_pkg::CMD_DESTROY, 3'd3, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // empty
        send_item(wzh_pkg::CMD_RAISE,   3'd7, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // empty
        send_item(wzh_pkg::CMD_CREATE,  3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00);
        send_item(wzh_pkg::CMD_HIT,     3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // 1x1 hit
        send_item(wzh_pkg::CMD_HIT,     3'd0, 12'd1, 12'd0, 12'd0, 12'd0, 8'h00); // miss
        // right/bottom edge sums beyond 12 bits must not wrap
        send_item(wzh_pkg::CMD_CREATE, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
        send_item(wzh_pkg::CMD_HIT,    3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
        send_item(wzh_pkg::CMD_CREATE, 3'd0, 12'd100, 12'd100, 12'd200, 12'd50, 8'hA5);
        send_item(wzh_pkg::CMD_HIT, 3'd0, 12'd300, 12'd150, 12'd0, 12'd0, 8'h00); // corner
        send_item(wzh_pkg::CMD_HIT, 3'd0, 12'd300, 12'd151, 12'd0, 12'd0, 8'h00); // just out
        send_item(wzh_pkg::CMD_CREATE, 3'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 8'h5A);
        send_item(wzh_pkg::CMD_HIT, 3'd0, 12'd100, 12'd100, 12'd0, 12'd0, 8'h00); // top wins
        send_item(wzh_pkg::CMD_RAISE,   3'd2, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00);
        send_item(wzh_pkg::CMD_HIT, 3'd0, 12'd100, 12'd100, 12'd0, 12'd0, 8'h00);
        send_item(wzh_pkg::CMD_RAISE,   3'd2, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // on top
        send_item(wzh_pkg::CMD_DESTROY, 3'd2, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00); // focused
        send_item(wzh_pkg::CMD_HIT, 3'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 8'h00);
        repeat (5)
            send_item(wzh_pkg::CMD_CREATE, 3'd0,
                      wzh_pkg::COORD_W'($urandom), wzh_pkg::COORD_W'($urandom),
                      wzh_pkg::COORD_W'($urandom), wzh_pkg::COORD_W'($urandom),
                      wzh_pkg::OWNER_W'($urandom));
        send_item(wzh_pkg::CMD_CREATE,  3'd0, 12'd5, 12'd5, 12'd5, 12'd5, 8'h11); // full
        send_item(wzh_pkg::CMD_DESTROY, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'h00);

        // Random: alternating grow and shrink phases so the table swings between
        // nearly empty and full; hit tests random or aimed at the last window's edges.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            int                          pick;
            int                          grow;
            logic [wzh_pkg::COORD_W:0]   far_x;
            logic [wzh_pkg::COORD_W:0]   far_y;
            logic [wzh_pkg::COORD_W-1:0] hx;
            logic [wzh_pkg::COORD_W-1:0] hy;
            logic [wzh_pkg::SLOT_W-1:0]  rs;
            logic [wzh_pkg::COORD_W-1:0] r0, r1, r2, r3;
            logic [wzh_pkg::OWNER_W-1:0] ro;
            calm  = (n >= RANDOM_ITEMS - CALM_ITEMS);
            grow  = ((n / 60) % 2 == 0) ? 35 : 15;
            pick  = $urandom_range(0, 99);
            rs    = wzh_pkg::SLOT_W'($urandom);
            r0    = wzh_pkg::COORD_W'($urandom);
            r1    = wzh_pkg::COORD_W'($urandom);
            r2    = wzh_pkg::COORD_W'($urandom);
            r3    = wzh_pkg::COORD_W'($urandom);
            ro    = wzh_pkg::OWNER_W'($urandom);
            if (pick < grow) begin
                last_x = wzh_pkg::COORD_W'($urandom);
                last_y = wzh_pkg::COORD_W'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    last_w = wzh_pkg::COORD_W'($urandom_range(0, 15));
                    last_h = wzh_pkg::COORD_W'($urandom_range(0, 15));
                end else begin
                    last_w = wzh_pkg::COORD_W'($urandom);
                    last_h = wzh_pkg::COORD_W'($urandom);
                end
                send_item(wzh_pkg::CMD_CREATE, rs, last_x, last_y, last_w, last_h, ro);
            end else if (pick < 50) begin
                send_item(wzh_pkg::CMD_DESTROY, rs, r0, r1, r2, r3, ro);
            end else if (pick < 65) begin
                send_item(wzh_pkg::CMD_RAISE, rs, r0, r1, r2, r3, ro);
            end else begin
                far_x = 13'(last_x) + 13'(last_w);
                far_y = 13'(last_y) + 13'(last_h);
                if (far_x > 13'hFFF) far_x = 13'hFFF;
                if (far_y > 13'hFFF) far_y = 13'hFFF;
                case ($urandom_range(0, 3))
                    0: begin
                        hx = r0;
                        hy = r1;
                    end
                    1: begin
                        hx = far_x[wzh_pkg::COORD_W-1:0];
                        hy = far_y[wzh_pkg::COORD_W-1:0];
                    end
                    2: begin
                        hx = last_x;
                        hy = last_y;
                    end
                    default: begin
                        // one step past the right edge, or left of the left edge
                        hx = (far_x < 13'hFFF) ? far_x[wzh_pkg::COORD_W-1:0] + 1'b1
                                               : last_x - 1'b1;
                        hy = last_y;
                    end
                endcase
                send_item(wzh_pkg::CMD_HIT, rs, hx, hy, r2, r3, ro);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_count != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wzh_pkg.sv
rtl/wzh_cell.sv
rtl/window_zorder_hit_test.sv
dv/wzh_stack_checker.sv
dv/tb.sv
